@@ sv/two_speed_fan_hysteresis_control_core_macros.svh @@
// Assertion helpers for the fan controller checkers.
`ifndef TWO_SPEED_FAN_HYSTERESIS_CONTROL_CORE_MACROS_SVH
`define TWO_SPEED_FAN_HYSTERESIS_CONTROL_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSFHC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSFHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tsfhc_pkg.sv @@
`default_nettype none

package tsfhc_pkg;

   typedef logic signed [7:0] temp_type;

   typedef enum logic [2:0] {
      MODE_INIT     = 3'd0,
      MODE_HI_FIRST = 3'd1,
      MODE_LO_FIRST = 3'd2,
      MODE_LO       = 3'd3,
      MODE_HI       = 3'd4,
      MODE_OFF      = 3'd5
   } mode_type;

   localparam int CSR_INDEX_BITS = 3;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_HIGH_TO_LOW_TEMP = 3'd0;
   localparam csr_index_type CSR_LOW_TO_HIGH_TEMP = 3'd1;
   localparam csr_index_type CSR_OFF_TO_HIGH_TEMP = 3'd2;
   localparam csr_index_type CSR_STOP_TEMP        = 3'd3;
   localparam csr_index_type CSR_READY_MAX_TEMP   = 3'd4;
   localparam csr_index_type CSR_FIRST_RUN_MS     = 3'd5;
   localparam csr_index_type CSR_HIGH_HOLD_MS     = 3'd6;
   localparam csr_index_type CSR_LOW_HOLD_MS      = 3'd7;

   localparam temp_type HIGH_TO_LOW_TEMP_RST = 8'sd55;
   localparam temp_type LOW_TO_HIGH_TEMP_RST = 8'sd60;
   localparam temp_type OFF_TO_HIGH_TEMP_RST = 8'sd40;
   localparam temp_type STOP_TEMP_RST        = 8'sd35;
   localparam temp_type READY_MAX_TEMP_RST   = 8'sd85;

   localparam int FIRST_RUN_MS_RST = 5000;
   localparam int HIGH_HOLD_MS_RST = 60000;
   localparam int LOW_HOLD_MS_RST  = 10000;

endpackage

`default_nettype wire

@@ sv/tsfhc_if.sv @@
`default_nettype none

interface tsfhc_req_if;
   logic                 valid;
   logic                 ready;
   tsfhc_pkg::temp_type  temperature;

   modport source (output valid, output temperature, input ready);
   modport sink   (input valid, input temperature, output ready);
endinterface

interface tsfhc_rsp_if;
   logic        valid;
   logic        ready;
   logic        fan_high;
   logic        fan_low;
   logic        ready_res;
   logic [2:0]  mode_code;

   modport source (output valid, output fan_high, output fan_low, output ready_res,
                   output mode_code, input ready);
   modport sink   (input valid, input fan_high, input fan_low, input ready_res,
                   input mode_code, output ready);
endinterface

`default_nettype wire

@@ sv/two_speed_fan_hysteresis_control_core.sv @@
// Two-speed fan controller with hysteresis.
// req_chan carries one millisecond tick per transfer with a signed temperature;
// rsp_chan returns one result per tick: fan_high, fan_low, ready_res and the
// mode code after that tick's update. The user must write thresholds and timer
// lengths through csr_wr_en / csr_index / csr_wdata only while no tick is in
// flight; the block does not enforce this. Two register stages: a tick taken
// from req_chan is captured in the input register, updates the mode state when
// the result register can take it, and is then offered on rsp_chan. One tick
// per clock is sustained unless rsp_chan stalls; the mode, counter and command
// registers are updated once per tick and double as the result register.
// Reset (synchronous, active high) restores the default thresholds and timer
// lengths, puts the controller in init mode and empties both stages.
// When rsp_chan is stalled the result holds; one more tick is taken into the
// input register, after which req_chan.ready drops until the result moves.
`default_nettype none

module two_speed_fan_hysteresis_control_core #(
   parameter int TIMER_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   tsfhc_req_if.sink                    req_chan,
   tsfhc_rsp_if.source                  rsp_chan,
   input  wire                          csr_wr_en,
   input  wire tsfhc_pkg::csr_index_type csr_index,
   input  wire [TIMER_BITS-1:0]         csr_wdata
);
   import tsfhc_pkg::*;

   localparam int CNT_BITS = TIMER_BITS + 1;

   temp_type                high_to_low_ff, low_to_high_ff, off_to_high_ff;
   temp_type                stop_ff, ready_max_ff;
   logic [TIMER_BITS-1:0]   first_run_ff, high_hold_ff, low_hold_ff;

   logic                    in_valid_ff, in_valid_in;
   temp_type                temp_ff;

   mode_type                mode_ff, mode_in;
   logic                    entry_ff, entry_in;
   logic [CNT_BITS-1:0]     tick_ff, tick_in;
   logic                    high_cmd_ff, high_cmd_in;
   logic                    low_cmd_ff, low_cmd_in;
   logic                    ready_res_ff, ready_res_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    step;
   logic                    req_xfer;
   logic [CNT_BITS-1:0]     tick_inc;
   logic                    below_stop;

   assign step     = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign req_chan.ready     = !in_valid_ff || step;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.fan_high  = high_cmd_ff;
   assign rsp_chan.fan_low   = low_cmd_ff;
   assign rsp_chan.ready_res = ready_res_ff;
   assign rsp_chan.mode_code = mode_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_to_low_ff <= HIGH_TO_LOW_TEMP_RST;
         low_to_high_ff <= LOW_TO_HIGH_TEMP_RST;
         off_to_high_ff <= OFF_TO_HIGH_TEMP_RST;
         stop_ff        <= STOP_TEMP_RST;
         ready_max_ff   <= READY_MAX_TEMP_RST;
         first_run_ff   <= TIMER_BITS'(FIRST_RUN_MS_RST);
         high_hold_ff   <= TIMER_BITS'(HIGH_HOLD_MS_RST);
         low_hold_ff    <= TIMER_BITS'(LOW_HOLD_MS_RST);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HIGH_TO_LOW_TEMP: high_to_low_ff <= csr_wdata[7:0];
            CSR_LOW_TO_HIGH_TEMP: low_to_high_ff <= csr_wdata[7:0];
            CSR_OFF_TO_HIGH_TEMP: off_to_high_ff <= csr_wdata[7:0];
            CSR_STOP_TEMP:        stop_ff        <= csr_wdata[7:0];
            CSR_READY_MAX_TEMP:   ready_max_ff   <= csr_wdata[7:0];
            CSR_FIRST_RUN_MS:     first_run_ff   <= csr_wdata;
            CSR_HIGH_HOLD_MS:     high_hold_ff   <= csr_wdata;
            CSR_LOW_HOLD_MS:      low_hold_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input stage
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         temp_ff <= req_chan.temperature;
      end
   end

   // next mode and counter
   assign tick_inc   = (entry_ff ? '0 : tick_ff) + CNT_BITS'(1);
   assign below_stop = temp_ff < stop_ff;

   always_comb begin
      mode_in = mode_ff;
      tick_in = tick_ff;
      case (mode_ff)
         MODE_INIT: begin
            mode_in = MODE_HI_FIRST;
         end
         MODE_HI_FIRST: begin
            tick_in = tick_inc;
            if (tick_inc > {1'b0, first_run_ff}) begin
               mode_in = below_stop ? MODE_OFF : MODE_LO_FIRST;
            end
         end
         MODE_LO_FIRST: begin
            tick_in = tick_inc;
            if (tick_inc > {1'b0, first_run_ff}) begin
               if (below_stop) begin
                  mode_in = MODE_OFF;
               end else if (temp_ff > low_to_high_ff) begin
                  mode_in = MODE_HI;
               end else begin
                  mode_in = MODE_LO;
               end
            end
         end
         MODE_LO: begin
            tick_in = tick_inc;
            if (tick_inc > {1'b0, low_hold_ff}) begin
               tick_in = {1'b0, low_hold_ff};
               if (below_stop) begin
                  mode_in = MODE_OFF;
               end else if (temp_ff > low_to_high_ff) begin
                  mode_in = MODE_HI;
               end
            end
         end
         MODE_HI: begin
            tick_in = tick_inc;
            if (tick_inc > {1'b0, high_hold_ff}) begin
               tick_in = {1'b0, high_hold_ff};
               if (below_stop) begin
                  mode_in = MODE_OFF;
               end else if (temp_ff < high_to_low_ff) begin
                  mode_in = MODE_LO;
               end
            end
         end
         MODE_OFF: begin
            if (temp_ff > off_to_high_ff) begin
               mode_in = MODE_HI;
            end
         end
         default: begin
         end
      endcase
      entry_in = mode_in != mode_ff;
   end

   // fan commands
   always_comb begin
      high_cmd_in = high_cmd_ff;
      low_cmd_in  = low_cmd_ff;
      case (mode_ff)
         MODE_INIT: begin
            high_cmd_in = 1'b0;
            low_cmd_in  = 1'b0;
         end
         MODE_HI_FIRST, MODE_HI: begin
            if (entry_ff) begin
               high_cmd_in = 1'b1;
               low_cmd_in  = 1'b0;
            end
         end
         MODE_LO_FIRST, MODE_LO: begin
            if (entry_ff) begin
               high_cmd_in = 1'b0;
               low_cmd_in  = 1'b1;
            end
         end
         MODE_OFF: begin
            if (entry_ff) begin
               high_cmd_in = 1'b0;
               low_cmd_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
      ready_res_in = !(temp_ff > ready_max_ff);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INIT;
         entry_ff     <= 1'b1;
         tick_ff      <= '0;
         high_cmd_ff  <= 1'b0;
         low_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            mode_ff     <= mode_in;
            entry_ff    <= entry_in;
            tick_ff     <= tick_in;
            high_cmd_ff <= high_cmd_in;
            low_cmd_ff  <= low_cmd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         ready_res_ff <= ready_res_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/tsfhc_checker.sv @@
`default_nettype none
`include "two_speed_fan_hysteresis_control_core_macros.svh"

module tsfhc_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire        fan_high,
   input wire        fan_low,
   input wire        ready_res,
   input wire [2:0]  mode_code
);
   import tsfhc_pkg::*;

   `TSFHC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(fan_high) && $stable(fan_low) && $stable(ready_res) && $stable(mode_code), "stalled result changed")

   `TSFHC_ASSERT_NOW(a_fan_exclusive, clock, reset, rsp_valid, !(fan_high && fan_low), "both fan speeds commanded")

   `TSFHC_ASSERT_NOW(a_no_init_result, clock, reset, rsp_valid, mode_code != MODE_INIT, "result reports init mode")

endmodule

bind two_speed_fan_hysteresis_control_core tsfhc_checker u_tsfhc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .fan_high  (rsp_chan.fan_high),
   .fan_low   (rsp_chan.fan_low),
   .ready_res (rsp_chan.ready_res),
   .mode_code (rsp_chan.mode_code)
);

`default_nettype wire

@@ verif/two_speed_fan_hysteresis_control_core_tb.sv @@
module two_speed_fan_hysteresis_control_core_tb;
   import tsfhc_pkg::*;

   localparam int TIMER_BITS   = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_TICKS  = 160;
   localparam int PHASE_COUNT  = 8;
   localparam int PRINT_LIMIT  = 50;

   typedef struct packed {
      logic       fan_high;
      logic       fan_low;
      logic       ready_res;
      logic [2:0] mode_code;
   } fan_cmd_t;

   class fan_cmd_scoreboard;
      temp_type              high_to_low;
      temp_type              low_to_high;
      temp_type              off_to_high;
      temp_type              stop_at;
      temp_type              ready_max;
      logic [TIMER_BITS-1:0] first_run;
      logic [TIMER_BITS-1:0] high_hold;
      logic [TIMER_BITS-1:0] low_hold;
      mode_type              mode;
      logic [2:0]            prev_mode;
      logic [TIMER_BITS:0]   ms_count;
      logic                  high_cmd;
      logic                  low_cmd;
      fan_cmd_t              pending_cmds[$];
      int                    error_count;

      function new();
         high_to_low = HIGH_TO_LOW_TEMP_RST;
         low_to_high = LOW_TO_HIGH_TEMP_RST;
         off_to_high = OFF_TO_HIGH_TEMP_RST;
         stop_at     = STOP_TEMP_RST;
         ready_max   = READY_MAX_TEMP_RST;
         first_run   = TIMER_BITS'(FIRST_RUN_MS_RST);
         high_hold   = TIMER_BITS'(HIGH_HOLD_MS_RST);
         low_hold    = TIMER_BITS'(LOW_HOLD_MS_RST);
         mode        = MODE_INIT;
         prev_mode   = 3'd7;
         ms_count    = '0;
         high_cmd    = 1'b0;
         low_cmd     = 1'b0;
         error_count = 0;
      endfunction

      function void report(string what);
         error_count++;
         if (error_count <= PRINT_LIMIT) $display("ERROR: %s", what);
      endfunction

      function void write_reg(csr_index_type idx, logic [TIMER_BITS-1:0] data);
         case (idx)
            CSR_HIGH_TO_LOW_TEMP: high_to_low = data[7:0];
            CSR_LOW_TO_HIGH_TEMP: low_to_high = data[7:0];
            CSR_OFF_TO_HIGH_TEMP: off_to_high = data[7:0];
            CSR_STOP_TEMP:        stop_at     = data[7:0];
            CSR_READY_MAX_TEMP:   ready_max   = data[7:0];
            CSR_FIRST_RUN_MS:     first_run   = data;
            CSR_HIGH_HOLD_MS:     high_hold   = data;
            CSR_LOW_HOLD_MS:      low_hold    = data;
            default: ;
         endcase
      endfunction

      function void note_tick(temp_type t);
         fan_cmd_t want;
         logic     entry;
         want.ready_res = (t > ready_max) ? 1'b0 : 1'b1;
         entry = (mode != prev_mode);
         prev_mode = mode;
         case (mode)
            MODE_INIT: begin
               high_cmd = 1'b0;
               low_cmd  = 1'b0;
               mode     = MODE_HI_FIRST;
            end
            MODE_HI_FIRST: begin
               if (entry) begin
                  high_cmd = 1'b1;
                  low_cmd  = 1'b0;
                  ms_count = '0;
               end
               ms_count = ms_count + (TIMER_BITS+1)'(1);
               if (ms_count > {1'b0, first_run})
                  mode = (t < stop_at) ? MODE_OFF : MODE_LO_FIRST;
            end
            MODE_LO_FIRST: begin
               if (entry) begin
                  high_cmd = 1'b0;
                  low_cmd  = 1'b1;
                  ms_count = '0;
               end
               ms_count = ms_count + (TIMER_BITS+1)'(1);
               if (ms_count > {1'b0, first_run}) begin
                  if (t < stop_at) mode = MODE_OFF;
                  else if (t > low_to_high) mode = MODE_HI;
                  else mode = MODE_LO;
               end
            end
            MODE_LO: begin
               if (entry) begin
                  high_cmd = 1'b0;
                  low_cmd  = 1'b1;
                  ms_count = '0;
               end
               ms_count = ms_count + (TIMER_BITS+1)'(1);
               if (ms_count > {1'b0, low_hold}) begin
                  ms_count = {1'b0, low_hold};
                  if (t > low_to_high) mode = MODE_HI;
                  if (t < stop_at) mode = MODE_OFF;
               end
            end
            MODE_HI: begin
               if (entry) begin
                  high_cmd = 1'b1;
                  low_cmd  = 1'b0;
                  ms_count = '0;
               end
               ms_count = ms_count + (TIMER_BITS+1)'(1);
               if (ms_count > {1'b0, high_hold}) begin
                  ms_count = {1'b0, high_hold};
                  if (t < high_to_low) mode = MODE_LO;
                  if (t < stop_at) mode = MODE_OFF;
               end
            end
            MODE_OFF: begin
               if (entry) begin
                  high_cmd = 1'b0;
                  low_cmd  = 1'b0;
               end
               if (t > off_to_high) mode = MODE_HI;
            end
            default: ;
         endcase
         want.fan_high  = high_cmd;
         want.fan_low   = low_cmd;
         want.mode_code = mode;
         pending_cmds.push_back(want);
      endfunction

      function void check_cmd(fan_cmd_t got);
         fan_cmd_t want;
         if (pending_cmds.size() == 0) begin
            report($sformatf("result with none expected: %b", got));
            return;
         end
         want = pending_cmds.pop_front();
         if (got.fan_high !== want.fan_high)
            report($sformatf("fan_high got %b want %b", got.fan_high, want.fan_high));
         if (got.fan_low !== want.fan_low)
            report($sformatf("fan_low got %b want %b", got.fan_low, want.fan_low));
         if (got.ready_res !== want.ready_res)
            report($sformatf("ready_res got %b want %b", got.ready_res, want.ready_res));
         if (got.mode_code !== want.mode_code)
            report($sformatf("mode_code got %0d want %0d", got.mode_code, want.mode_code));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [TIMER_BITS-1:0] csr_wdata;
   logic [TIMER_BITS-1:0] reg_vals [8];
   int                    req_idle_pct;
   int                    rsp_stall_pct;
   int                    cycle_count;
   fan_cmd_scoreboard     fan_sb;

   tsfhc_req_if req_if();
   tsfhc_rsp_if rsp_if();

   two_speed_fan_hysteresis_control_core #(.TIMER_BITS(TIMER_BITS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         fan_sb.check_cmd(fan_cmd_t'({rsp_if.fan_high, rsp_if.fan_low, rsp_if.ready_res,
                                      rsp_if.mode_code}));
      rsp_if.ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
   end

   function automatic logic [TIMER_BITS-1:0] temp_word(int v);
      return {8'($urandom_range(255)), v[7:0]};
   endfunction

   // mostly near a live threshold, otherwise anywhere in range
   function automatic temp_type pick_temp();
      int v;
      if ($urandom_range(99) < 40) return temp_type'($urandom);
      v = int'($signed(reg_vals[$urandom_range(CSR_READY_MAX_TEMP, CSR_HIGH_TO_LOW_TEMP)][7:0]));
      v = v + int'($urandom_range(8)) - 4;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return temp_type'(v);
   endfunction

   task automatic set_idling(int sel);
      case (sel % 4)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 52; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 52; end
         default: begin req_idle_pct = 13; rsp_stall_pct = 13; end
      endcase
   endtask

   task automatic choose_regs(int phase);
      int c;
      int hl;
      c  = int'($urandom_range(180)) - 90;
      hl = c + int'($urandom_range(1, 10));
      reg_vals[CSR_STOP_TEMP]        = temp_word(c);
      reg_vals[CSR_OFF_TO_HIGH_TEMP] = temp_word(c + int'($urandom_range(1, 8)));
      reg_vals[CSR_HIGH_TO_LOW_TEMP] = temp_word(hl);
      reg_vals[CSR_LOW_TO_HIGH_TEMP] = temp_word(hl + int'($urandom_range(1, 8)));
      reg_vals[CSR_READY_MAX_TEMP]   = temp_word(c + int'($urandom_range(37)));
      reg_vals[CSR_FIRST_RUN_MS]     = TIMER_BITS'($urandom_range(6));
      reg_vals[CSR_HIGH_HOLD_MS]     = TIMER_BITS'($urandom_range(10));
      reg_vals[CSR_LOW_HOLD_MS]      = TIMER_BITS'($urandom_range(10));
      case (phase)
         2: begin
            reg_vals[CSR_FIRST_RUN_MS] = TIMER_BITS'($urandom_range(40));
            reg_vals[CSR_HIGH_HOLD_MS] = TIMER_BITS'($urandom_range(60));
            reg_vals[CSR_LOW_HOLD_MS]  = TIMER_BITS'($urandom_range(60));
         end
         3, 7: begin
            // thresholds in any order, so off can win against a rise
            for (int i = CSR_HIGH_TO_LOW_TEMP; i <= CSR_READY_MAX_TEMP; i++)
               reg_vals[i] = TIMER_BITS'($urandom);
            if (phase == 7) begin
               reg_vals[CSR_FIRST_RUN_MS] = TIMER_BITS'($urandom_range(3));
               reg_vals[CSR_HIGH_HOLD_MS] = TIMER_BITS'($urandom_range(3));
               reg_vals[CSR_LOW_HOLD_MS]  = TIMER_BITS'($urandom_range(3));
            end
         end
         4: begin
            reg_vals[CSR_HIGH_TO_LOW_TEMP] = temp_word(127);
            reg_vals[CSR_LOW_TO_HIGH_TEMP] = temp_word(-128);
            reg_vals[CSR_OFF_TO_HIGH_TEMP] = temp_word(-128);
            reg_vals[CSR_STOP_TEMP]        = temp_word(127);
            reg_vals[CSR_READY_MAX_TEMP]   = temp_word(-128);
            reg_vals[CSR_FIRST_RUN_MS]     = '1;
            reg_vals[CSR_HIGH_HOLD_MS]     = '1;
            reg_vals[CSR_LOW_HOLD_MS]      = '1;
         end
         5: begin
            reg_vals[CSR_HIGH_TO_LOW_TEMP] = temp_word(-128);
            reg_vals[CSR_LOW_TO_HIGH_TEMP] = temp_word(127);
            reg_vals[CSR_OFF_TO_HIGH_TEMP] = temp_word(127);
            reg_vals[CSR_STOP_TEMP]        = temp_word(-128);
            reg_vals[CSR_READY_MAX_TEMP]   = temp_word(127);
            reg_vals[CSR_FIRST_RUN_MS]     = '0;
            reg_vals[CSR_HIGH_HOLD_MS]     = '0;
            reg_vals[CSR_LOW_HOLD_MS]      = '0;
         end
         default: ;
      endcase
   endtask

   task automatic program_regs();
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= reg_vals[i];
         @(posedge clock);
         fan_sb.write_reg(csr_index_type'(i), reg_vals[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_tick(temp_type t);
      while (int'($urandom_range(99)) < req_idle_pct) begin
         req_if.valid       <= 1'b0;
         req_if.temperature <= temp_type'($urandom);
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.temperature <= t;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      fan_sb.note_tick(t);
   endtask

   task automatic wait_results_done();
      while (fan_sb.pending_cmds.size() != 0) @(posedge clock);
   endtask

   initial begin
      int reset_temps[6] = '{-128, 127, 85, 86, 0, -1};
      int walk_temps[18] = '{25, 25, 25, 25, 25, 25, 40, 40, 40, 40, 15,
                             15, 15, 15, -5, 5, 50, 51};
      fan_sb             = new();
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_HIGH_TO_LOW_TEMP;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.temperature = '0;
      rsp_if.ready       = 1'b0;
      cycle_count        = 0;
      set_idling(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (reset_temps[i]) send_tick(temp_type'(reset_temps[i]));
      req_if.valid <= 1'b0;
      wait_results_done();

      // short timers: walk first runs, low, high, back to low and back to high
      reg_vals[CSR_HIGH_TO_LOW_TEMP] = temp_word(20);
      reg_vals[CSR_LOW_TO_HIGH_TEMP] = temp_word(30);
      reg_vals[CSR_OFF_TO_HIGH_TEMP] = temp_word(10);
      reg_vals[CSR_STOP_TEMP]        = temp_word(0);
      reg_vals[CSR_READY_MAX_TEMP]   = temp_word(50);
      reg_vals[CSR_FIRST_RUN_MS]     = TIMER_BITS'(2);
      reg_vals[CSR_HIGH_HOLD_MS]     = TIMER_BITS'(3);
      reg_vals[CSR_LOW_HOLD_MS]      = TIMER_BITS'(3);
      program_regs();
      foreach (walk_temps[i]) send_tick(temp_type'(walk_temps[i]));
      req_if.valid <= 1'b0;
      wait_results_done();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         choose_regs(ph);
         program_regs();
         set_idling(ph);
         for (int n = 0; n < PHASE_TICKS; n++) send_tick(pick_temp());
         req_if.valid <= 1'b0;
         wait_results_done();
      end

      repeat (8) @(posedge clock);
      if (fan_sb.error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
